[hw/rtl/fbc_pkg.sv]
package fbc_pkg;

  // key loaded at reset and taken on restart until reconfigured
  localparam logic [31:0] KEY_RESET_VALUE = 32'hF69D_A025;

  // outcome of one cipher round
  typedef struct packed {
    logic [31:0] key;
    logic [7:0]  out_byte;
  } round_res_t;

endpackage

[hw/rtl/fbc_in_if.sv]
interface fbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       restart;
  logic       field_end;

  modport source (output valid, output data_byte, output restart, output field_end,
                  input ready);
  modport sink   (input valid, input data_byte, input restart, input field_end,
                  output ready);
endinterface

[hw/rtl/fbc_out_if.sv]
interface fbc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       field_end_out;

  modport source (output valid, output out_byte, output field_end_out, input ready);
  modport sink   (input valid, input out_byte, input field_end_out, output ready);
endinterface

[hw/rtl/fbc_round.sv]
module fbc_round
  import fbc_pkg::*;
(
  input  logic [31:0] key,
  input  logic [7:0]  data_byte,
  output round_res_t  res
);

  logic [15:0] x0;
  logic [15:0] y0;
  logic [31:0] prod;
  logic [15:0] x1;
  logic [7:0]  kbyte;
  logic [15:0] x2;
  logic [15:0] y2;

  // split key and multiply the halves
  assign x0   = key[31:16];
  assign y0   = key[15:0];
  assign prod = 32'(x0) * 32'(y0);

  // low half decremented, wraps at zero, mixed with high half
  assign x1    = (prod[15:0] - 16'd1) ^ prod[31:16];
  assign kbyte = x1[7:0];

  // feed the plain byte back into the key
  assign x2 = {x1[15:8], data_byte};
  assign y2 = x2 ^ {8'h00, kbyte};

  assign res.key      = {x2, y2};
  assign res.out_byte = y2[7:0];

endmodule

[hw/rtl/feedback_byte_cipher_core.sv]
// Byte stream cipher with a 32-bit running key. One byte beat is accepted every
// clock unless the output stalls; each result goes through the input register,
// then the result register. The rate is set by the key feedback path: one
// 16x16 multiply, a decrement and a few xors from the key register back into itself,
// so every byte's key update completes in the cycle it leaves the input register. A
// beat with restart set starts from the configured initial key instead of the running
// key; the end marker is carried through untouched and does not affect the key. The
// key register and the configured initial key both come out of reset as 0xF69DA025,
// and a configuration write only takes effect at the next restart.
module feedback_byte_cipher_core
  import fbc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  fbc_in_if.sink      in_bus,
  fbc_out_if.source   out_bus
);

  logic [31:0] cfg_key_r;
  logic [31:0] key_r;
  logic        s1_valid_r;
  logic [7:0]  s1_data_r;
  logic        s1_restart_r;
  logic        s1_end_r;
  logic        out_valid_r;
  logic [7:0]  out_byte_r;
  logic        out_end_r;

  logic        out_free;
  logic        s1_adv;
  logic [31:0] key_src;
  round_res_t  round_res;

  // handshake: result register frees up when empty or being taken
  assign out_free     = !out_valid_r || out_bus.ready;
  assign s1_adv       = s1_valid_r && out_free;
  assign in_bus.ready = !s1_valid_r || s1_adv;

  // configuration register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_key_r <= KEY_RESET_VALUE;
    end else if (cfg_we) begin
      cfg_key_r <= cfg_wdata;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_bus.ready) begin
      s1_valid_r <= in_bus.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_bus.ready && in_bus.valid) begin
      s1_data_r    <= in_bus.data_byte;
      s1_restart_r <= in_bus.restart;
      s1_end_r     <= in_bus.field_end;
    end
  end

  // cipher round on the running or reloaded key
  assign key_src = s1_restart_r ? cfg_key_r : key_r;

  fbc_round u_round (
    .key       (key_src),
    .data_byte (s1_data_r),
    .res       (round_res)
  );

  // running key advances with each beat leaving the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r <= KEY_RESET_VALUE;
    end else if (s1_adv) begin
      key_r <= round_res.key;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_byte_r <= round_res.out_byte;
      out_end_r  <= s1_end_r;
    end
  end

  assign out_bus.valid         = out_valid_r;
  assign out_bus.out_byte      = out_byte_r;
  assign out_bus.field_end_out = out_end_r;

  // key only moves when a beat passes into the result register
  a_key_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> $stable(key_r))
    else $error("running key changed without a beat advancing");

  // a stalled beat in the input register is kept intact
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && !s1_adv) |=> (s1_valid_r && $stable(s1_data_r) && $stable(s1_end_r)))
    else $error("stalled input beat lost or altered");

  // a new result only appears after a beat advanced
  a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_adv))
    else $error("result valid without an advancing beat");

endmodule

[tb/sv/feedback_byte_cipher_core_test.sv]
`timescale 1ns / 100ps

module feedback_byte_cipher_core_test;

  localparam logic [31:0] KEY_AT_RESET = 32'hF69D_A025;

  // one byte beat towards the core
  typedef struct packed {
    logic [7:0] data;
    logic       restart;
    logic       field_end;
  } byte_beat_t;

  // one cipher result beat
  typedef struct packed {
    logic [7:0] out_byte;
    logic       field_end;
  } cipher_beat_t;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  fbc_in_if  in_bus ();
  fbc_out_if out_bus ();

  feedback_byte_cipher_core u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_bus    (in_bus),
    .out_bus   (out_bus)
  );

  byte_beat_t   pending_bytes[$];
  cipher_beat_t expected_bytes[$];
  logic [31:0]  key_cfg;
  logic [31:0]  key_run;
  int unsigned  send_idle_pct;
  int unsigned  recv_stall_pct;
  int unsigned  err_count;

  always #10 clk = ~clk;

  // one round of the running key; returns the new key, cipher byte out by argument
  function automatic logic [31:0] advance_key(input logic [31:0] key,
                                              input logic [7:0] din,
                                              output logic [7:0] dout);
    logic [31:0] prod;
    logic [15:0] hi;
    logic [15:0] lo;
    logic [7:0]  kbyte;
    prod  = key[31:16] * key[15:0];
    hi    = prod[15:0] - 16'd1;
    hi    = hi ^ prod[31:16];
    kbyte = hi[7:0];
    hi    = {hi[15:8], din};
    lo    = hi ^ {8'h00, kbyte};
    dout  = lo[7:0];
    return {hi, lo};
  endfunction

  // byte driver, predicts the result of every accepted beat
  always @(posedge clk) begin : drive_bytes
    byte_beat_t   nxt;
    cipher_beat_t res;
    logic [7:0]   ob;
    if (!rst_n) begin
      in_bus.valid <= 1'b0;
    end else begin
      if (in_bus.valid && in_bus.ready) begin
        if (in_bus.restart)
          key_run = key_cfg;
        key_run = advance_key(key_run, in_bus.data_byte, ob);
        res.out_byte  = ob;
        res.field_end = in_bus.field_end;
        expected_bytes.push_back(res);
      end
      if (!in_bus.valid || in_bus.ready) begin
        if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_bytes.pop_front();
          in_bus.valid     <= 1'b1;
          in_bus.data_byte <= nxt.data;
          in_bus.restart   <= nxt.restart;
          in_bus.field_end <= nxt.field_end;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // result monitor with random back-pressure
  always @(posedge clk) begin : watch_results
    cipher_beat_t exp_beat;
    if (!rst_n) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected beat out_byte=%h field_end_out=%b", $time,
                   out_bus.out_byte, out_bus.field_end_out);
          err_count++;
        end else begin
          exp_beat = expected_bytes.pop_front();
          if (out_bus.out_byte !== exp_beat.out_byte) begin
            $display("%0t: out_byte expected %h actual %h", $time,
                     exp_beat.out_byte, out_bus.out_byte);
            err_count++;
          end
          if (out_bus.field_end_out !== exp_beat.field_end) begin
            $display("%0t: field_end_out expected %b actual %b", $time,
                     exp_beat.field_end, out_bus.field_end_out);
            err_count++;
          end
        end
      end
      out_bus.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] d, input logic rs, input logic fe);
    byte_beat_t b;
    b.data      = d;
    b.restart   = rs;
    b.field_end = fe;
    pending_bytes.push_back(b);
  endtask

  // wait until the core has nothing in flight, checked once all edge updates settle
  task automatic drain;
    @(posedge clk);
    while (pending_bytes.size() != 0 || in_bus.valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_key(input logic [31:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    key_cfg = v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // mostly whole runs (restart first, end marker last), some loose bytes
  task automatic fill_random(input int unsigned n);
    int unsigned cnt;
    int unsigned len;
    cnt = 0;
    while (cnt < n) begin
      if ($urandom_range(9) < 8) begin
        len = $urandom_range(24, 1);
        for (int unsigned i = 0; i < len; i++)
          push_byte(8'($urandom_range(255)), i == 0, i == len - 1);
        cnt += len;
      end else begin
        push_byte(8'($urandom_range(255)), 1'($urandom_range(1)),
                  1'($urandom_range(1)));
        cnt++;
      end
    end
  endtask

  initial begin : stimulus
    logic [31:0] keys[8];
    rst_n            = 1'b0;
    cfg_we           = 1'b0;
    cfg_wdata        = 32'h0;
    in_bus.valid     = 1'b0;
    in_bus.data_byte = 8'h00;
    in_bus.restart   = 1'b0;
    in_bus.field_end = 1'b0;
    out_bus.ready    = 1'b0;
    key_cfg          = KEY_AT_RESET;
    key_run          = KEY_AT_RESET;
    send_idle_pct    = 24;
    recv_stall_pct   = 24;
    err_count        = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // reset key, running from reset state first, then restarts
    push_byte(8'h00, 1'b0, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'hA5, 1'b0, 1'b1);
    push_byte(8'h5A, 1'b1, 1'b0);
    push_byte(8'h00, 1'b1, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    drain();

    // zero key: product is zero so the decrement wraps; first byte keeps old key
    write_key(32'h0000_0000);
    push_byte(8'h3C, 1'b0, 1'b0);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b1);
    push_byte(8'hFF, 1'b1, 1'b1);
    drain();

    write_key(32'hFFFF_FFFF);
    push_byte(8'h00, 1'b1, 1'b0);
    push_byte(8'hFF, 1'b0, 1'b0);
    push_byte(8'h81, 1'b0, 1'b1);
    drain();

    // low half zero and a product with an all-zero low half
    write_key(32'hFFFF_0000);
    push_byte(8'h7E, 1'b1, 1'b1);
    push_byte(8'h01, 1'b0, 1'b0);
    drain();
    write_key(32'h0100_0100);
    push_byte(8'h80, 1'b1, 1'b0);
    push_byte(8'h7F, 1'b0, 1'b1);
    drain();

    keys[0] = 32'h0000_FFFF;
    keys[1] = 32'hFFFF_FFFF;
    keys[2] = 32'h0000_0000;
    keys[3] = KEY_AT_RESET;
    for (int i = 4; i < 8; i++)
      keys[i] = $urandom();

    // random phases, one without any idling on either side
    for (int i = 0; i < 8; i++) begin
      write_key(keys[i]);
      send_idle_pct  = (i == 4) ? 0 : 24;
      recv_stall_pct = (i == 4) ? 0 : 24;
      fill_random(180);
      drain();
    end

    repeat (10) @(posedge clk);
    if (expected_bytes.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, expected_bytes.size());
      err_count++;
    end
    if (err_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // overall time limit
  initial begin : watchdog
    #4_000_000;
    $display("FAIL");
    $finish;
  end

endmodule
